// File: design/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/minstk_pkg.sv
package minstk_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_LD,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        t_status status;
        logic    push;
        logic    pop;
        logic    load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

// File: design/minstk_dp.sv
module minstk_dp #(
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [minstk_pkg::VALUE_W-1:0]  i_value,
    input  minstk_pkg::t_dp_cmd                    i_cmd,
    output minstk_pkg::t_dp_stat                   o_stat,
    output logic signed [minstk_pkg::VALUE_W-1:0]  o_top_value,
    output logic signed [minstk_pkg::VALUE_W-1:0]  o_min_value,
    output logic [minstk_pkg::COUNT_W-1:0]         o_count,
    output logic                                   o_is_empty,
    output logic [1:0]                             o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // entries below the top live in memory, the top itself in registers
    logic signed [minstk_pkg::VALUE_W-1:0] mem_val [DEPTH];
    logic signed [minstk_pkg::VALUE_W-1:0] mem_min [DEPTH];

    logic signed [minstk_pkg::VALUE_W-1:0] r_rd_val, r_rd_min;
    logic signed [minstk_pkg::VALUE_W-1:0] r_top_val, r_top_min;
    logic [CW-1:0]                         r_count;
    minstk_pkg::t_status                   r_status;

    logic signed [minstk_pkg::VALUE_W-1:0] r_out_top, r_out_min;
    logic [minstk_pkg::COUNT_W-1:0]        r_out_count;
    logic                                  r_out_empty;
    minstk_pkg::t_status                   r_out_status;

    logic [CW-1:0]                         cnt_m1, cnt_m2;
    logic [AW-1:0]                         wr_addr, rd_addr;
    logic signed [minstk_pkg::VALUE_W-1:0] new_min;
    logic                                  empty;

    assign empty   = (r_count == '0);
    assign cnt_m1  = r_count - CW'(1);
    assign cnt_m2  = r_count - CW'(2);
    assign wr_addr = cnt_m1[AW-1:0];
    assign rd_addr = cnt_m2[AW-1:0];

    assign new_min = (empty || (i_value < r_top_min)) ? i_value : r_top_min;

    assign o_stat.empty = empty;
    assign o_stat.full  = (r_count == CW'(DEPTH));

    // old top spills to memory on push; entry below top is always being read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !empty) begin
            mem_val[wr_addr] <= r_top_val;
            mem_min[wr_addr] <= r_top_min;
        end
        r_rd_val <= mem_val[rd_addr];
        r_rd_min <= mem_min[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop) begin
            r_count <= cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top_val <= i_value;
            r_top_min <= new_min;
        end else if (i_cmd.pop) begin
            r_top_val <= r_rd_val;
            r_top_min <= r_rd_min;
        end
        if (i_cmd.accept) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.load_out) begin
            r_out_top    <= empty ? '0 : r_top_val;
            r_out_min    <= empty ? '0 : r_top_min;
            r_out_count  <= minstk_pkg::COUNT_W'(r_count);
            r_out_empty  <= empty;
            r_out_status <= r_status;
        end
    end

    assign o_top_value = r_out_top;
    assign o_min_value = r_out_min;
    assign o_count     = r_out_count;
    assign o_is_empty  = r_out_empty;
    assign o_status    = r_out_status;

endmodule

// File: design/minstk_ctrl.sv
module minstk_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic [minstk_pkg::CMD_W-1:0]        i_cmd,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  minstk_pkg::t_dp_stat                i_stat,
    output minstk_pkg::t_dp_cmd                 o_cmd
);

    minstk_pkg::t_state r_state, n_state;
    logic               r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= minstk_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.status = minstk_pkg::ST_OK;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            minstk_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = minstk_pkg::S_EMIT;
                    if (i_cmd == minstk_pkg::CMD_PUSH) begin
                        if (i_stat.full) begin
                            o_cmd.status = minstk_pkg::ST_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end else if (i_cmd == minstk_pkg::CMD_POP) begin
                        if (i_stat.empty) begin
                            o_cmd.status = minstk_pkg::ST_EMPTY;
                        end else begin
                            n_state = minstk_pkg::S_POP_LD;
                        end
                    end
                end
            end
            minstk_pkg::S_POP_LD: begin
                // memory read of the entry below the top has landed
                o_cmd.pop = 1'b1;
                n_state   = minstk_pkg::S_EMIT;
            end
            minstk_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = minstk_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = minstk_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != minstk_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: design/stack_with_running_minimum.sv
// Bounded LIFO stack of signed 32-bit values that also reports the smallest value held.
// Each input beat is a push, pop or query (cmds 2 and 3 act as queries) and yields exactly one
// result beat with top, minimum, count, empty flag and status; top and minimum read 0
// when empty, refused pushes and pops leave the stack unchanged. Push, query and refused
// operations load the result register in the emit state after the accepting state, once
// the output side is not stalling; a successful pop first passes a pop-load state, since
// the new top comes from the entry memory whose read data is registered. The next beat is
// taken once the result has been loaded, so beats do not overlap. The entry memory holds
// DEPTH values and minima and needs no clearing after reset.
module stack_with_running_minimum #(
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [minstk_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [minstk_pkg::VALUE_W-1:0] i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [minstk_pkg::VALUE_W-1:0] o_top_value,
    output logic signed [minstk_pkg::VALUE_W-1:0] o_min_value,
    output logic [minstk_pkg::COUNT_W-1:0]        o_count,
    output logic                                  o_is_empty,
    output logic [1:0]                            o_status
);

    minstk_pkg::t_dp_cmd  dp_cmd;
    minstk_pkg::t_dp_stat dp_stat;

    minstk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    minstk_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_top_value (o_top_value),
        .o_min_value (o_min_value),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_status    (o_status)
    );

endmodule

// File: design/minstk_checker.sv
`include "assert_macros.svh"

module minstk_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic [minstk_pkg::CMD_W-1:0]          i_cmd,
    input logic signed [minstk_pkg::VALUE_W-1:0] i_value,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [minstk_pkg::VALUE_W-1:0] o_top_value,
    input logic signed [minstk_pkg::VALUE_W-1:0] o_min_value,
    input logic [minstk_pkg::COUNT_W-1:0]        o_count,
    input logic                                  o_is_empty,
    input logic [1:0]                            o_status
);

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_top_value) && $stable(o_min_value) && $stable(o_status))

    // empty stack shows zero count, top and minimum
    `ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_out_valid && o_is_empty, o_count == '0 && o_top_value == '0 && o_min_value == '0)

    // a refused pop leaves the stack empty
    `ASSERT_SAME(a_underflow_empty, i_clk, i_rst_n, o_out_valid && o_status == minstk_pkg::ST_EMPTY, o_is_empty)

    // running minimum never exceeds the top
    `ASSERT_SAME(a_min_le_top, i_clk, i_rst_n, o_out_valid && !o_is_empty, o_min_value <= o_top_value)

endmodule

bind stack_with_running_minimum minstk_checker u_minstk_checker (.*);
